>>> design/rcbp_pkg.sv
// ----------------------------------------------------------------------------
// rcbp_pkg
// shared types and codes of the reference-counted buffer pool
// ----------------------------------------------------------------------------
package rcbp_pkg;

  localparam int ID_W           = 6;
  localparam int MAX_BUFFERS    = 1 << ID_W;
  localparam int POOL_W         = 7;
  localparam int COUNT_BITS_DEF = 8;
  localparam int STATUS_W       = 3;
  localparam int NEW_COUNT_W    = 8;
  localparam int OP_W           = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_GET     = 2'd0;
  localparam logic [OP_W-1:0] OP_RETAIN  = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_HELD     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREE_RELEASE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL         = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [ID_W-1:0] buffer_id;
  } rcbp_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [ID_W-1:0]        granted_id;
    logic [NEW_COUNT_W-1:0] new_count;
    logic                   recycled;
    logic [POOL_W-1:0]      free_count;
  } rcbp_out_t;

endpackage

>>> design/rcbp_ram.sv
// ----------------------------------------------------------------------------
// rcbp_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module rcbp_ram #(
  parameter int WIDTH = rcbp_pkg::COUNT_BITS_DEF,
  parameter int DEPTH = rcbp_pkg::MAX_BUFFERS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/refcounted_buffer_pool.sv
// an accepted beat sits in the operation stage until the output register is free
// one beat per cycle unless the output stalls; counts and free ring are read as a
// beat is accepted and written back with forwarding into the next read
// reset and every pool size write start a clearing pass over all MAX_BUFFERS entries
// that fills the free ring and zeroes the counts; no beat is taken during it
// ----------------------------------------------------------------------------
// refcounted_buffer_pool
// buffer pool with a fifo free ring and a reference count per buffer
// ----------------------------------------------------------------------------
module refcounted_buffer_pool #(
  parameter int COUNT_BITS = rcbp_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rcbp_pkg::rcbp_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rcbp_pkg::rcbp_out_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [rcbp_pkg::POOL_W-1:0]   cfg_wr_data
);

  import rcbp_pkg::*;

  // clearing pass
  logic              sweep_r, sweep_nxt;
  logic [ID_W-1:0]   sweep_idx_r, sweep_idx_nxt;

  // ring and pool state
  logic [POOL_W-1:0] pool_size_r, pool_size_nxt;
  logic [ID_W-1:0]   head_r, head_nxt;
  logic [ID_W-1:0]   tail_r, tail_nxt;
  logic [POOL_W-1:0] free_total_r, free_total_nxt;
  logic [POOL_W-1:0] cfg_size;

  // operation stage
  logic              s1_valid_r, s1_valid_nxt;
  logic [OP_W-1:0]   s1_op_r;
  logic [ID_W-1:0]   s1_id_r;
  logic              s1_fire;
  logic              in_accept;
  logic              in_pool;

  // forwarding of write-back into the following read
  logic              fwd_cnt_hit_r;
  logic [COUNT_BITS-1:0] fwd_cnt_r;
  logic              fwd_ring_hit_r;
  logic [ID_W-1:0]   fwd_ring_r;

  // memory ports
  logic                  cnt_we;
  logic [ID_W-1:0]       cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic                  ring_we;
  logic [ID_W-1:0]       ring_waddr;
  logic [ID_W-1:0]       ring_wdata;
  logic [ID_W-1:0]       ring_rdata;

  // operation write requests
  logic                  op_cnt_we;
  logic [ID_W-1:0]       op_cnt_addr;
  logic [COUNT_BITS-1:0] op_cnt_data;
  logic                  op_ring_we;

  logic [COUNT_BITS-1:0] cnt_cur;
  logic [ID_W-1:0]       ring_cur;
  logic [COUNT_BITS-1:0] res_cnt;
  logic [COUNT_BITS+NEW_COUNT_W-1:0] res_cnt_ext;
  rcbp_out_t             res;

  logic                  out_valid_r, out_valid_nxt;
  rcbp_out_t             out_data_r;

  function automatic logic [ID_W-1:0] ring_next(input logic [ID_W-1:0] p,
                                                input logic [POOL_W-1:0] size);
    logic [POOL_W-1:0] inc;
    inc = {1'b0, p} + POOL_W'(1);
    return (inc >= size) ? '0 : inc[ID_W-1:0];
  endfunction

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !sweep_r && (!s1_valid_r || s1_fire);
  assign in_accept = in_valid && in_ready;
  assign in_pool   = {1'b0, s1_id_r} < pool_size_r;
  assign cnt_cur   = fwd_cnt_hit_r ? fwd_cnt_r : cnt_rdata;
  assign ring_cur  = fwd_ring_hit_r ? fwd_ring_r : ring_rdata;

  always_comb begin
    priority if (cfg_wr_data == '0) begin
      cfg_size = POOL_W'(1);
    end else if (cfg_wr_data > POOL_W'(MAX_BUFFERS)) begin
      cfg_size = POOL_W'(MAX_BUFFERS);
    end else begin
      cfg_size = cfg_wr_data;
    end
  end

  // operation evaluation
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_total_nxt = free_total_r;
    op_cnt_we      = 1'b0;
    op_cnt_addr    = s1_id_r;
    op_cnt_data    = cnt_cur;
    op_ring_we     = 1'b0;
    res_cnt        = '0;
    res.status     = ST_OK;
    res.granted_id = s1_id_r;
    res.recycled   = 1'b0;
    unique case (s1_op_r)
      OP_GET: begin
        res.granted_id = '0;
        if (free_total_r == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.granted_id = ring_cur;
          res_cnt        = COUNT_BITS'(1);
          op_cnt_we      = s1_fire;
          op_cnt_addr    = ring_cur;
          op_cnt_data    = COUNT_BITS'(1);
          if (s1_fire) begin
            head_nxt       = ring_next(head_r, pool_size_r);
            free_total_nxt = free_total_r - POOL_W'(1);
          end
        end
      end
      OP_RETAIN: begin
        priority if (!in_pool || cnt_cur == '0) begin
          res.status = ST_NOT_HELD;
        end else if (cnt_cur == '1) begin
          res.status = ST_FULL;
          res_cnt    = cnt_cur;
        end else begin
          res_cnt     = cnt_cur + COUNT_BITS'(1);
          op_cnt_we   = s1_fire;
          op_cnt_data = cnt_cur + COUNT_BITS'(1);
        end
      end
      OP_RELEASE: begin
        priority if (!in_pool) begin
          res.status = ST_NOT_HELD;
        end else if (cnt_cur == '0) begin
          res.status = ST_FREE_RELEASE;
        end else begin
          res_cnt     = cnt_cur - COUNT_BITS'(1);
          op_cnt_we   = s1_fire;
          op_cnt_data = cnt_cur - COUNT_BITS'(1);
          if (res_cnt == '0 && free_total_r < pool_size_r) begin
            res.recycled = 1'b1;
            op_ring_we   = s1_fire;
            if (s1_fire) begin
              tail_nxt       = ring_next(tail_r, pool_size_r);
              free_total_nxt = free_total_r + POOL_W'(1);
            end
          end
        end
      end
      default: begin
        res_cnt = in_pool ? cnt_cur : '0;
      end
    endcase
    res_cnt_ext    = {{NEW_COUNT_W{1'b0}}, res_cnt};
    res.new_count  = res_cnt_ext[NEW_COUNT_W-1:0];
    res.free_count = (free_total_r == '0 && s1_op_r == OP_GET) ? free_total_r
                                                              : free_total_nxt;
    pool_size_nxt  = pool_size_r;
    if (cfg_wr_en) begin
      pool_size_nxt  = cfg_size;
      head_nxt       = '0;
      tail_nxt       = '0;
      free_total_nxt = cfg_size;
    end
  end

  // memory write selection
  always_comb begin
    if (sweep_r) begin
      cnt_we     = 1'b1;
      cnt_waddr  = sweep_idx_r;
      cnt_wdata  = '0;
      ring_we    = 1'b1;
      ring_waddr = sweep_idx_r;
      ring_wdata = sweep_idx_r;
    end else begin
      cnt_we     = op_cnt_we;
      cnt_waddr  = op_cnt_addr;
      cnt_wdata  = op_cnt_data;
      ring_we    = op_ring_we;
      ring_waddr = tail_r;
      ring_wdata = s1_id_r;
    end
  end

  always_comb begin
    sweep_nxt     = sweep_r;
    sweep_idx_nxt = sweep_idx_r;
    if (cfg_wr_en) begin
      sweep_nxt     = 1'b1;
      sweep_idx_nxt = '0;
    end else if (sweep_r) begin
      sweep_idx_nxt = sweep_idx_r + ID_W'(1);
      if (sweep_idx_r == ID_W'(MAX_BUFFERS - 1)) begin
        sweep_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    s1_valid_nxt  = in_accept || (s1_valid_r && !s1_fire);
    out_valid_nxt = s1_fire || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r        <= 1'b1;
      sweep_idx_r    <= '0;
      pool_size_r    <= POOL_W'(MAX_BUFFERS);
      head_r         <= '0;
      tail_r         <= '0;
      free_total_r   <= POOL_W'(MAX_BUFFERS);
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      fwd_cnt_hit_r  <= 1'b0;
      fwd_ring_hit_r <= 1'b0;
    end else begin
      sweep_r        <= sweep_nxt;
      sweep_idx_r    <= sweep_idx_nxt;
      pool_size_r    <= pool_size_nxt;
      head_r         <= head_nxt;
      tail_r         <= tail_nxt;
      free_total_r   <= free_total_nxt;
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      if (in_accept) begin
        fwd_cnt_hit_r  <= cnt_we && (cnt_waddr == in_data.buffer_id);
        fwd_ring_hit_r <= ring_we && (ring_waddr == head_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r    <= in_data.operation;
      s1_id_r    <= in_data.buffer_id;
      fwd_cnt_r  <= cnt_wdata;
      fwd_ring_r <= ring_wdata;
    end
    if (s1_fire) begin
      out_data_r <= res;
    end
  end

  rcbp_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_BUFFERS)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (cnt_waddr),
    .wr_data (cnt_wdata),
    .rd_en   (in_accept),
    .rd_addr (in_data.buffer_id),
    .rd_data (cnt_rdata)
  );

  rcbp_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_BUFFERS)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_waddr),
    .wr_data (ring_wdata),
    .rd_en   (in_accept),
    .rd_addr (head_nxt),
    .rd_data (ring_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= pool_size_r)
    else $error("free total above pool size");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, head_r} < pool_size_r) && ({1'b0, tail_r} < pool_size_r))
    else $error("ring pointer beyond pool");

  a_ring_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (free_total_r == '0 || free_total_r == pool_size_r) |-> head_r == tail_r)
    else $error("ring pointers disagree with free total");

  a_recycle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.recycled) |->
      (out_data_r.new_count == '0 && out_data_r.status == ST_OK))
    else $error("recycled beat with nonzero count or error status");

endmodule
